### src/art_pkg.sv
// shared types, constants and register codes for the affine ray transform
`timescale 1ns / 1ps
`default_nettype none
package art_pkg;

  // fixed formats
  localparam int COEF_FRAC = 12;
  localparam int UNIT_ONE  = 16384;
  localparam int LANES     = 3;

  // pipeline depths of the parts
  localparam int LANE_LAT  = 3;
  localparam int NORM_LAT  = 6;
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 15;
  localparam int PIPE_LAT  = LANE_LAT + NORM_LAT + SQ_STEPS + DIV_STEPS;

  // widths inside the datapath
  localparam int DIR_W  = 50;
  localparam int MAG_W  = 49;
  localparam int NRM_W  = 30;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int CFG_W  = 48;

  // identity matrix rows after reset
  localparam logic [CFG_W-1:0] ROW0_RST = 48'h0000_0000_1000;
  localparam logic [CFG_W-1:0] ROW1_RST = 48'h0000_1000_0000;
  localparam logic [CFG_W-1:0] ROW2_RST = 48'h1000_0000_0000;

  typedef enum logic [2:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_OFFX = 3'd3,
    REG_OFFY = 3'd4,
    REG_OFFZ = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic        func;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [15:0] unit_x;
    logic [15:0] unit_y;
    logic [15:0] unit_z;
    logic        zero_direction;
    logic        saturated;
  } res_t;

endpackage
`default_nettype wire

### src/art_lane.sv
// one matrix row: position and direction dot products, rounding, offset and clamp
`timescale 1ns / 1ps
`default_nettype none
module art_lane import art_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [CFG_W-1:0]         row,
  input  wire logic [31:0]              off,
  input  wire logic [2:0][31:0]         pos,
  input  wire logic [2:0][31:0]         dir,
  output logic      [31:0]              pos_o,
  output logic                          sat_o,
  output logic      [DIR_W-1:0]         dir_o
);

  logic signed [47:0]      pp [3];
  logic signed [47:0]      dp [3];
  logic signed [DIR_W-1:0] psum;
  logic signed [DIR_W-1:0] dsum;
  logic signed [37:0]      sh;
  logic signed [38:0]      r;
  logic [31:0]             pos_next;
  logic                    sat_next;

  // stage 1: six products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp[i] <= $signed(row[16*i +: 16]) * $signed(pos[i]);
        dp[i] <= $signed(row[16*i +: 16]) * $signed(dir[i]);
      end
    end
  end

  // stage 2: sums with rounding bias on the position
  always_ff @(posedge clk) begin
    if (en) begin
      psum <= DIR_W'(pp[0]) + DIR_W'(pp[1]) + DIR_W'(pp[2])
              + DIR_W'(1 << (COEF_FRAC - 1));
      dsum <= DIR_W'(dp[0]) + DIR_W'(dp[1]) + DIR_W'(dp[2]);
    end
  end

  // floor shift, offset and clamp to 32 bits
  always_comb begin
    sh = psum[DIR_W-1:COEF_FRAC];
    r  = {sh[37], sh} + {{7{off[31]}}, off};
    if (r[38:31] == 8'h00 || r[38:31] == 8'hff) begin
      pos_next = r[31:0];
      sat_next = 1'b0;
    end else begin
      pos_next = r[38] ? 32'h8000_0000 : 32'h7fff_ffff;
      sat_next = 1'b1;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      pos_o <= pos_next;
      sat_o <= sat_next;
      dir_o <= dsum;
    end
  end

endmodule
`default_nettype wire

### src/art_norm.sv
// direction scaling: magnitudes, leading-one search, common shift and squared length
`timescale 1ns / 1ps
`default_nettype none
module art_norm import art_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [2:0][DIR_W-1:0]       d,
  output logic      [2:0][NRM_W-1:0]       a_o,
  output logic      [2:0]                  sgn_o,
  output logic                             zero_o,
  output logic      [SUM_W-1:0]            s_o
);

  localparam int GRP   = 7;
  localparam int GRP_N = MAG_W / GRP;
  localparam int TGT   = NRM_W - 1;

  logic [2:0][MAG_W-1:0] m1, m2, m3;
  logic [2:0]            sg1, sg2, sg3, sg4, sg5;
  logic [MAG_W-1:0]      orv;
  logic [GRP_N-1:0]      nz;
  logic [2:0]            gi [GRP_N];
  logic [GRP_N-1:0]      nz_next;
  logic [2:0]            gi_next [GRP_N];
  logic [5:0]            p;
  logic                  right3;
  logic [4:0]            amt3;
  logic                  z3, z4, z5;
  logic [2:0][NRM_W-1:0] a4, a5;
  logic [2*NRM_W-1:0]    sq [3];
  logic [DIR_W-1:0]      neg;

  // stage 1: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i]  <= d[i][DIR_W-1] ? MAG_W'(-d[i]) : d[i][MAG_W-1:0];
        sg1[i] <= d[i][DIR_W-1];
      end
    end
  end
  assign neg = '0;

  // leading one per group of the or of all magnitudes
  always_comb begin
    orv = m1[0] | m1[1] | m1[2] | MAG_W'(neg);
    for (int g = 0; g < GRP_N; g++) begin
      nz_next[g] = |orv[g*GRP +: GRP];
      gi_next[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        if (orv[g*GRP + b]) gi_next[g] = 3'(b);
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      m2  <= m1;
      sg2 <= sg1;
      nz  <= nz_next;
      for (int g = 0; g < GRP_N; g++) gi[g] <= gi_next[g];
    end
  end

  // pick the highest group and derive the shift
  always_comb begin
    p = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (nz[g]) p = 6'(g * GRP) + 6'(gi[g]);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      m3     <= m2;
      sg3    <= sg2;
      z3     <= ~|nz;
      right3 <= (p >= 6'(TGT));
      amt3   <= (p >= 6'(TGT)) ? 5'(p - 6'(TGT)) : 5'(6'(TGT) - p);
    end
  end

  // stage 4: common shift
  always_ff @(posedge clk) begin
    if (en) begin
      sg4 <= sg3;
      z4  <= z3;
      for (int i = 0; i < 3; i++) begin
        a4[i] <= right3 ? NRM_W'(m3[i] >> amt3) : NRM_W'(m3[i] << amt3);
      end
    end
  end

  // stage 5: squares
  always_ff @(posedge clk) begin
    if (en) begin
      sg5 <= sg4;
      z5  <= z4;
      a5  <= a4;
      for (int i = 0; i < 3; i++) sq[i] <= a4[i] * a4[i];
    end
  end

  // stage 6: squared length
  always_ff @(posedge clk) begin
    if (en) begin
      sgn_o  <= sg5;
      zero_o <= z5;
      a_o    <= a5;
      s_o    <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

endmodule
`default_nettype wire

### src/art_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module art_sqrt import art_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SUM_W-1:0]  x,
  output logic      [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 4;

  logic [SUM_W-1:0]  xs [SQ_STEPS];
  logic [REM_W-1:0]  rm [SQ_STEPS];
  logic [ROOT_W-1:0] rt [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [SUM_W-1:0]  x_in;
    logic [REM_W-1:0]  r_in;
    logic [ROOT_W-1:0] q_in;
    logic [REM_W-1:0]  r_sh;
    logic [REM_W-1:0]  t;

    if (k == 0) begin : g_first
      assign x_in = x;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign x_in = xs[k-1];
      assign r_in = rm[k-1];
      assign q_in = rt[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      r_sh = {r_in[REM_W-3:0], x_in[2*(SQ_STEPS-1-k) +: 2]};
      t    = {2'b00, q_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= x_in;
        if (r_sh >= t) begin
          rm[k] <= r_sh - t;
          rt[k] <= {q_in[ROOT_W-2:0], 1'b1};
        end else begin
          rm[k] <= r_sh;
          rt[k] <= {q_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[SQ_STEPS-1];

endmodule
`default_nettype wire

### src/art_div.sv
// pipelined rounded divide of a scaled magnitude by the length, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module art_div import art_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [NRM_W-1:0]     num,
  input  wire logic [ROOT_W-1:0]    den,
  output logic      [DIV_STEPS-1:0] q
);

  localparam int UNIT_SH = $clog2(UNIT_ONE);
  localparam int REM_W   = NRM_W + UNIT_SH + 1;

  logic [REM_W-1:0]     rm [DIV_STEPS];
  logic [DIV_STEPS-1:0] qv [DIV_STEPS];
  logic [ROOT_W-1:0]    dv [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [REM_W-1:0]     r_in;
    logic [DIV_STEPS-1:0] q_in;
    logic [ROOT_W-1:0]    d_in;
    logic [REM_W-1:0]     dsh;

    if (j == 0) begin : g_first
      // numerator with half the divisor for rounding
      assign r_in = REM_W'({num, {UNIT_SH{1'b0}}}) + REM_W'(den >> 1);
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign r_in = rm[j-1];
      assign q_in = qv[j-1];
      assign d_in = dv[j-1];
    end

    assign dsh = REM_W'(d_in) << (DIV_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j] <= d_in;
        if (r_in >= dsh) begin
          rm[j] <= r_in - dsh;
          qv[j] <= q_in | (DIV_STEPS'(1) << (DIV_STEPS - 1 - j));
        end else begin
          rm[j] <= r_in;
          qv[j] <= q_in;
        end
      end
    end
  end

  assign q = qv[DIV_STEPS-1];

endmodule
`default_nettype wire

### src/affine_ray_transform.sv
// affine ray transform top level: config registers, row lanes, normalizer and merge
// throughput: one beat per cycle while the skid is empty; most of the depth is in the
// square root (31 stages) and the per-component divide (15 stages) pipelines
// a two-entry output (register plus skid) holds results while res is stalled
// reset clears valids and the skid, and loads the identity matrix with zero offset
`timescale 1ns / 1ps
`default_nettype none
module affine_ray_transform import art_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_idx,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             ray_valid,
  output logic                  ray_stall,
  input  wire ray_t             ray_item,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_t                  res_item
);

  localparam int A_DL   = SQ_STEPS;
  localparam int SG_DL  = SQ_STEPS + DIV_STEPS;
  localparam int POS_DL = NORM_LAT + SQ_STEPS + DIV_STEPS;

  logic [CFG_W-1:0]          row [3];
  logic [31:0]               offs [3];
  logic                      adv;
  logic [PIPE_LAT-1:0]       vld;
  logic                      fn_dl [PIPE_LAT];
  logic [2:0][31:0]          pin, din;
  logic [2:0][31:0]          lp;
  logic [2:0]                ls;
  logic [2:0][DIR_W-1:0]     ld;
  logic [96:0]               pos_dl [POS_DL];
  logic [2:0][NRM_W-1:0]     na;
  logic [2:0]                nsg;
  logic                      nz;
  logic [SUM_W-1:0]          ns;
  logic [ROOT_W-1:0]         len;
  logic [2:0][NRM_W-1:0]     a_dl [A_DL];
  logic [3:0]                sg_dl [SG_DL];
  logic [DIV_STEPS-1:0]      q [3];
  logic [15:0]               u [3];
  res_t                      merged;
  res_t                      skid;
  logic                      skid_full;
  logic                      arrive;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row[0]  <= ROW0_RST;
      row[1]  <= ROW1_RST;
      row[2]  <= ROW2_RST;
      offs[0] <= '0;
      offs[1] <= '0;
      offs[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_idx))
        REG_ROW0: row[0]  <= cfg_data;
        REG_ROW1: row[1]  <= cfg_data;
        REG_ROW2: row[2]  <= cfg_data;
        REG_OFFX: offs[0] <= cfg_data[31:0];
        REG_OFFY: offs[1] <= cfg_data[31:0];
        REG_OFFZ: offs[2] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // the whole pipe moves unless the skid holds a beat
  assign adv       = !skid_full;
  assign ray_stall = skid_full;

  // valid and mode shift lines
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], ray_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn_dl[0] <= ray_item.func;
      for (int i = 1; i < PIPE_LAT; i++) fn_dl[i] <= fn_dl[i-1];
    end
  end

  assign pin = {ray_item.pos_z, ray_item.pos_y, ray_item.pos_x};
  assign din = {ray_item.dir_z, ray_item.dir_y, ray_item.dir_x};

  // one lane per matrix row
  for (genvar r = 0; r < LANES; r++) begin : g_lane
    art_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .row   (row[r]),
      .off   (offs[r]),
      .pos   (pin),
      .dir   (din),
      .pos_o (lp[r]),
      .sat_o (ls[r]),
      .dir_o (ld[r])
    );
  end

  // positions wait for the direction path
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_dl[0] <= {|ls, lp};
      for (int i = 1; i < POS_DL; i++) pos_dl[i] <= pos_dl[i-1];
    end
  end

  art_norm u_norm (
    .clk    (clk),
    .en     (adv),
    .d      (ld),
    .a_o    (na),
    .sgn_o  (nsg),
    .zero_o (nz),
    .s_o    (ns)
  );

  art_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    (ns),
    .root (len)
  );

  // scaled magnitudes wait for the length, signs for the quotient
  always_ff @(posedge clk) begin
    if (adv) begin
      a_dl[0]  <= na;
      sg_dl[0] <= {nz, nsg};
      for (int i = 1; i < A_DL; i++)  a_dl[i]  <= a_dl[i-1];
      for (int i = 1; i < SG_DL; i++) sg_dl[i] <= sg_dl[i-1];
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_div
    art_div u_div (
      .clk (clk),
      .en  (adv),
      .num (a_dl[A_DL-1][c]),
      .den (len),
      .q   (q[c])
    );
  end

  // merge: clamp, sign and special cases
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      u[c] = (q[c] > DIV_STEPS'(UNIT_ONE)) ? 16'(UNIT_ONE) : 16'(q[c]);
      if (fn_dl[PIPE_LAT-1] || sg_dl[SG_DL-1][3]) begin
        u[c] = '0;
      end else if (sg_dl[SG_DL-1][c]) begin
        u[c] = -u[c];
      end
    end
    merged.out_x          = pos_dl[POS_DL-1][31:0];
    merged.out_y          = pos_dl[POS_DL-1][63:32];
    merged.out_z          = pos_dl[POS_DL-1][95:64];
    merged.unit_x         = u[0];
    merged.unit_y         = u[1];
    merged.unit_z         = u[2];
    merged.zero_direction = !fn_dl[PIPE_LAT-1] && sg_dl[SG_DL-1][3];
    merged.saturated      = pos_dl[POS_DL-1][96];
  end

  assign arrive = adv && vld[PIPE_LAT-1];

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_full) begin
        res_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        res_valid <= arrive;
      end
    end else if (arrive) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      res_item <= skid_full ? skid : merged;
    end else if (arrive) begin
      skid <= merged;
    end
  end

endmodule
`default_nettype wire

### src/art_checker.sv
// port checks for the affine ray transform, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module art_checker import art_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic ray_stall,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire res_t res_item
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result beat changed");

  // a zero direction carries zero unit fields
  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.zero_direction |->
      res_item.unit_x == '0 && res_item.unit_y == '0 && res_item.unit_z == '0)
    else $error("zero direction with non-zero unit vector");

  // input back-pressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(ray_stall) |-> $past(res_valid && res_stall))
    else $error("input stalled without output stall");

  // unit components stay within one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      ($signed(res_item.unit_x) <= 16'sd16384 && $signed(res_item.unit_x) >= -16'sd16384) &&
      ($signed(res_item.unit_y) <= 16'sd16384 && $signed(res_item.unit_y) >= -16'sd16384) &&
      ($signed(res_item.unit_z) <= 16'sd16384 && $signed(res_item.unit_z) >= -16'sd16384))
    else $error("unit component out of range");

endmodule

bind affine_ray_transform art_checker u_art_checker (
  .clk       (clk),
  .rst       (rst),
  .ray_stall (ray_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);
`default_nettype wire

### tb/art_checker.sv
// checker for the affine ray transform: watches both channels, predicts and compares
`timescale 1ns / 1ps
module art_scoreboard import art_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             ray_valid,
  input  logic             ray_stall,
  input  ray_t             ray_item,
  input  logic             res_valid,
  input  logic             res_stall,
  input  res_t             res_item,
  output int               fail_count,
  output int               pending,
  output int               rays_seen,
  output int               points_seen
);

  logic [CFG_W-1:0] row_q [3];
  logic [31:0]      off_q [3];
  res_t             expected_q [$];

  // signed Q4.12 coefficient from a packed row
  function automatic longint coef_of(input logic [CFG_W-1:0] row, input int col);
    logic signed [15:0] c;
    c = row[16*col +: 16];
    return longint'(c);
  endfunction

  function automatic longint dot_row(input logic [CFG_W-1:0] row, input longint v [3]);
    return coef_of(row, 0) * v[0] + coef_of(row, 1) * v[1] + coef_of(row, 2) * v[2];
  endfunction

  // integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] acc, bit_w;
    acc = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= acc + bit_w) begin
        x = x - (acc + bit_w);
        acc = (acc >> 1) + bit_w;
      end else begin
        acc = acc >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return acc;
  endfunction

  // expected transform of one beat
  function automatic res_t transform_ray(input ray_t r);
    res_t o;
    longint p [3], dv [3], d [3], s;
    logic [63:0] mag [3], m, sum, len, q;
    int rsh, lsh;
    logic [15:0] uv [3];
    logic sat, zero;
    logic signed [31:0] offs;
    p[0] = longint'($signed(r.pos_x)); p[1] = longint'($signed(r.pos_y));
    p[2] = longint'($signed(r.pos_z));
    dv[0] = longint'($signed(r.dir_x)); dv[1] = longint'($signed(r.dir_y));
    dv[2] = longint'($signed(r.dir_z));
    sat = 0; zero = 0;
    uv[0] = 0; uv[1] = 0; uv[2] = 0;
    for (int i = 0; i < 3; i++) begin
      offs = off_q[i];
      s = dot_row(row_q[i], p) + 2048;
      s = (s >>> 12) + longint'(offs);
      if (s > 64'sd2147483647) begin sat = 1; s = 64'sd2147483647; end
      if (s < -64'sd2147483648) begin sat = 1; s = -64'sd2147483648; end
      if (i == 0) o.out_x = s[31:0];
      else if (i == 1) o.out_y = s[31:0];
      else o.out_z = s[31:0];
    end
    if (!r.func) begin
      m = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = dot_row(row_q[i], dv);
        mag[i] = d[i] < 0 ? -d[i] : d[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        zero = 1;
      end else begin
        rsh = 0; lsh = 0;
        while (m >= (64'd1 << 30)) begin m = m >> 1; rsh++; end
        while (m < (64'd1 << 29)) begin m = m << 1; lsh++; end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (mag[i] >> rsh) << lsh;
          sum = sum + mag[i] * mag[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
          q = (mag[i] * UNIT_ONE + (len >> 1)) / len;
          if (q > UNIT_ONE) q = UNIT_ONE;
          uv[i] = d[i] < 0 ? 16'(-q) : q[15:0];
        end
      end
    end
    o.unit_x = uv[0]; o.unit_y = uv[1]; o.unit_z = uv[2];
    o.zero_direction = zero;
    o.saturated = sat;
    return o;
  endfunction

  // track registers, predict accepted beats, compare result beats
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      row_q[0] <= ROW0_RST; row_q[1] <= ROW1_RST; row_q[2] <= ROW2_RST;
      off_q[0] <= '0; off_q[1] <= '0; off_q[2] <= '0;
      expected_q.delete();
      fail_count <= 0; rays_seen <= 0; points_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROW0: row_q[0] <= cfg_data;
          REG_ROW1: row_q[1] <= cfg_data;
          REG_ROW2: row_q[2] <= cfg_data;
          REG_OFFX: off_q[0] <= cfg_data[31:0];
          REG_OFFY: off_q[1] <= cfg_data[31:0];
          REG_OFFZ: off_q[2] <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (ray_valid && !ray_stall) begin
        expected_q = {expected_q, transform_ray(ray_item)};
        if (ray_item.func) points_seen <= points_seen + 1;
        else rays_seen <= rays_seen + 1;
      end
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", res_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== res_item) begin
            if (fail_count < 10)
              $display("result mismatch: expected %p actual %p", want, res_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

### tb/tb.sv
// testbench top for the affine ray transform: stimulus, register phases and verdict
`timescale 1ns / 1ps
module tb;
  import art_pkg::*;

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_we = 0;
  logic [2:0]       cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             ray_valid = 0;
  logic             ray_stall;
  ray_t             ray_item = '0;
  logic             res_valid;
  logic             res_stall = 0;
  res_t             res_item;
  int               fail_count, pending, rays_seen, points_seen;
  int               send_idle = 0, recv_idle = 0;
  int               cycles = 0;

  always #1 clk = ~clk;

  affine_ray_transform u_top (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .ray_valid, .ray_stall, .ray_item,
    .res_valid, .res_stall, .res_item
  );

  art_scoreboard u_chk (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .ray_valid, .ray_stall, .ray_item,
    .res_valid, .res_stall, .res_item,
    .fail_count, .pending, .rays_seen, .points_seen
  );

  // receiver stall pattern
  always @(posedge clk) res_stall <= ($urandom_range(99) < recv_idle);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] mid_coord();
    logic signed [31:0] v;
    v = $urandom_range(32'h00ff_ffff);
    return $urandom_range(1) ? -v : v;
  endfunction

  // send one beat, idling at random beforehand
  task automatic send_ray(input ray_t r);
    while ($urandom_range(99) < send_idle) begin
      ray_valid <= 0;
      @(posedge clk);
    end
    ray_valid <= 1;
    ray_item <= r;
    @(posedge clk);
    while (ray_stall) @(posedge clk);
  endtask

  // hold off until every predicted result has been seen
  task automatic quiet_wait();
    ray_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic ray_t random_ray(input bit wide);
    ray_t r;
    r.func = $urandom_range(3) == 0;
    r.pos_x = wide ? edge_coord() : mid_coord();
    r.pos_y = wide ? edge_coord() : mid_coord();
    r.pos_z = wide ? edge_coord() : mid_coord();
    r.dir_x = wide ? edge_coord() : mid_coord();
    r.dir_y = wide ? edge_coord() : mid_coord();
    r.dir_z = wide ? edge_coord() : mid_coord();
    if ($urandom_range(15) == 0) begin r.dir_x = 0; r.dir_y = 0; r.dir_z = 0; end
    return r;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_matrix(input int style);
    logic [CFG_W-1:0] rows [3];
    logic [31:0] offs [3];
    for (int i = 0; i < 3; i++) begin
      case (style)
        0: rows[i] = {rand_coef(), rand_coef(), rand_coef()};
        1: rows[i] = {3{16'h7fff}};
        2: rows[i] = {3{16'h8000}};
        default: rows[i] = 48'h1000 << (16 * i);
      endcase
      offs[i] = style == 1 ? 32'h7fff_ffff : style == 2 ? 32'h8000_0000 : edge_coord();
    end
    write_reg(REG_ROW0, rows[0]);
    write_reg(REG_ROW1, rows[1]);
    write_reg(REG_ROW2, rows[2]);
    write_reg(REG_OFFX, {16'h0, offs[0]});
    write_reg(REG_OFFY, {16'h0, offs[1]});
    write_reg(REG_OFFZ, {16'h0, offs[2]});
  endtask

  initial begin
    ray_t r;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed beats with the identity matrix
    for (int k = 0; k < 12; k++) begin
      r = '0;
      r.func = k[0];
      case (k >> 1)
        0: ;
        1: begin r.pos_x = 32'h7fff_ffff; r.dir_x = 32'h8000_0000; end
        2: begin r.pos_y = 32'h8000_0000; r.dir_y = 32'h7fff_ffff; r.dir_z = 1; end
        3: begin r.pos_z = 32'hffff_ffff; r.dir_x = 1; r.dir_y = 1; r.dir_z = 1; end
        4: begin r.pos_x = 32'h0001_0000; r.dir_z = 32'hffff_ffff; end
        default: r = '1;
      endcase
      send_ray(r);
    end
    quiet_wait();
    // extreme matrices to force clamping
    for (int s = 1; s <= 2; s++) begin
      load_matrix(s);
      for (int k = 0; k < 6; k++) send_ray(random_ray(1));
      quiet_wait();
    end

    // random phases with varying idle patterns and settings
    for (int ph = 0; ph < 12; ph++) begin
      send_idle = ph < 4 ? 13 : ph < 8 ? 77 : 0;
      recv_idle = ph < 4 ? 77 : ph < 8 ? 13 : 0;
      load_matrix(ph == 11 ? 3 : 0);
      for (int k = 0; k < 115; k++) send_ray(random_ray($urandom_range(1)));
      quiet_wait();
    end

    $display("covered %0d rays and %0d points over fourteen matrix settings",
             rays_seen, points_seen);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
